// ===== rtl/core/tsc_pkg.sv =====
// tsc_pkg: types, class codes and the fixed-string tables of the token stream classifier
// used by every module under rtl/core; depends on nothing

package tsc_pkg;

  // token classes as reported on the result word
  typedef enum logic [3:0] {
    CLS_OP     = 4'd0,
    CLS_RELOP  = 4'd1,
    CLS_PUNCT  = 4'd2,
    CLS_LDELIM = 4'd3,
    CLS_RDELIM = 4'd4,
    CLS_KEYWD  = 4'd5,
    CLS_DTYPE  = 4'd6,
    CLS_ASSIG  = 4'd7,
    CLS_IDENT  = 4'd8,
    CLS_ERROR  = 4'd9
  } tsc_class_e;

  // why the block stopped
  typedef enum logic [1:0] {
    HALT_PERIOD = 2'd0,
    HALT_EOI    = 2'd1,
    HALT_ERROR  = 2'd2
  } tsc_halt_e;

  typedef enum logic {
    KIND_TOKEN   = 1'b0,
    KIND_SUMMARY = 1'b1
  } tsc_kind_e;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOI  = 1'b1
  } tsc_op_e;

  // input word
  typedef struct packed {
    tsc_op_e    operation;
    logic [7:0] ch;
  } tsc_in_word_t;

  // result word
  typedef struct packed {
    tsc_kind_e  result_kind;
    tsc_class_e token_class;
    logic       brackets_balanced;
    tsc_halt_e  halt_cause;
    logic       last;
  } tsc_out_word_t;

  // results produced by one item, first one first
  typedef struct packed {
    logic [1:0]    count;
    tsc_out_word_t first;
    tsc_out_word_t second;
  } tsc_push_t;

  localparam int unsigned NUM_FIXED = 25;
  localparam int unsigned IDX_BITS  = 5;
  localparam int unsigned POS_BITS  = 3;

  // fixed-string indexes that carry side effects
  localparam logic [IDX_BITS-1:0] IDX_PERIOD = 5'd12;
  localparam logic [IDX_BITS-1:0] IDX_LBRACE = 5'd13;
  localparam logic [IDX_BITS-1:0] IDX_LPAREN = 5'd14;
  localparam logic [IDX_BITS-1:0] IDX_RBRACE = 5'd15;
  localparam logic [IDX_BITS-1:0] IDX_RPAREN = 5'd16;

  // fixed strings, one byte per position, zero padded
  localparam logic [7:0] FIXED_TEXT [NUM_FIXED][8] = '{
    '{0: 8'h2b, default: 8'h00},                                         // +
    '{0: 8'h2d, default: 8'h00},                                         // -
    '{0: 8'h2f, default: 8'h00},                                         // /
    '{0: 8'h2a, default: 8'h00},                                         // *
    '{0: 8'h21, 1: 8'h3d, default: 8'h00},                               // !=
    '{0: 8'h3d, 1: 8'h3d, default: 8'h00},                               // ==
    '{0: 8'h3c, 1: 8'h3d, default: 8'h00},                               // <=
    '{0: 8'h3e, 1: 8'h3d, default: 8'h00},                               // >=
    '{0: 8'h3c, default: 8'h00},                                         // <
    '{0: 8'h3e, default: 8'h00},                                         // >
    '{0: 8'h3b, default: 8'h00},                                         // ;
    '{0: 8'h2c, default: 8'h00},                                         // ,
    '{0: 8'h2e, default: 8'h00},                                         // .
    '{0: 8'h7b, default: 8'h00},                                         // {
    '{0: 8'h28, default: 8'h00},                                         // (
    '{0: 8'h7d, default: 8'h00},                                         // }
    '{0: 8'h29, default: 8'h00},                                         // )
    '{0: 8'h69, 1: 8'h66, default: 8'h00},                               // if
    '{0: 8'h77, 1: 8'h68, 2: 8'h69, 3: 8'h6c, 4: 8'h65, default: 8'h00}, // while
    '{0: 8'h64, 1: 8'h6f, default: 8'h00},                               // do
    '{0: 8'h73, 1: 8'h77, 2: 8'h69, 3: 8'h74, 4: 8'h63, 5: 8'h68,
      default: 8'h00},                                                   // switch
    '{0: 8'h73, 1: 8'h68, 2: 8'h6f, 3: 8'h72, 4: 8'h74, default: 8'h00}, // short
    '{0: 8'h69, 1: 8'h6e, 2: 8'h74, default: 8'h00},                     // int
    '{0: 8'h6c, 1: 8'h6f, 2: 8'h6e, 3: 8'h67, default: 8'h00},           // long
    '{0: 8'h3d, default: 8'h00}                                          // =
  };

  localparam logic [POS_BITS-1:0] FIXED_LEN [NUM_FIXED] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd5, 3'd2, 3'd6, 3'd5, 3'd3, 3'd4, 3'd1
  };

  localparam tsc_class_e FIXED_CLASS [NUM_FIXED] = '{
    CLS_OP, CLS_OP, CLS_OP, CLS_OP,
    CLS_RELOP, CLS_RELOP, CLS_RELOP, CLS_RELOP, CLS_RELOP, CLS_RELOP,
    CLS_PUNCT, CLS_PUNCT, CLS_PUNCT,
    CLS_LDELIM, CLS_LDELIM, CLS_RDELIM, CLS_RDELIM,
    CLS_KEYWD, CLS_KEYWD, CLS_KEYWD, CLS_KEYWD,
    CLS_DTYPE, CLS_DTYPE, CLS_DTYPE,
    CLS_ASSIG
  };

endpackage

// ===== rtl/core/tsc_lexer.sv =====
// tsc_lexer: token matcher state, bracket counters and halt flag; turns one word
// into zero, one or two result words. depends on tsc_pkg

module tsc_lexer #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  tsc_pkg::tsc_in_word_t word_i,
  output tsc_pkg::tsc_push_t    push_o
);

  localparam logic [COUNT_BITS-1:0] CntMax = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CntMin = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  logic [tsc_pkg::NUM_FIXED-1:0] mask_q, mask_d, keep;
  logic                          lower_q, lower_d;
  logic [tsc_pkg::POS_BITS-1:0]  len_q, len_d;
  logic [COUNT_BITS-1:0]         paren_q, paren_d, brace_q, brace_d;
  logic                          ovf_q, ovf_d;
  logic                          halted_q, halted_d;

  logic                          hit;
  logic [tsc_pkg::IDX_BITS-1:0]  hit_idx;
  tsc_pkg::tsc_class_e           hit_cls, cls;
  logic                          space, eoi, period, is_err;
  tsc_pkg::tsc_out_word_t        tok_word, sum_word;

  assign eoi   = (word_i.operation == tsc_pkg::OP_EOI);
  assign space = ((word_i.ch >= 8'd9) && (word_i.ch <= 8'd13)) || (word_i.ch == 8'd32);

  // per-string match of the incoming byte at the current position
  always_comb begin
    for (int i = 0; i < tsc_pkg::NUM_FIXED; i++) begin
      keep[i] = (len_q < tsc_pkg::FIXED_LEN[i]) &&
                (tsc_pkg::FIXED_TEXT[i][len_q] == word_i.ch);
    end
  end

  // fixed string that the pending token equals, if any
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    hit_cls = tsc_pkg::CLS_OP;
    for (int i = 0; i < tsc_pkg::NUM_FIXED; i++) begin
      if (mask_q[i] && (tsc_pkg::FIXED_LEN[i] == len_q)) begin
        hit     = 1'b1;
        hit_idx = tsc_pkg::IDX_BITS'(i);
        hit_cls = tsc_pkg::FIXED_CLASS[i];
      end
    end
  end

  assign cls    = hit ? hit_cls :
                  ((lower_q && (len_q != '0)) ? tsc_pkg::CLS_IDENT : tsc_pkg::CLS_ERROR);
  assign is_err = (len_q != '0) && (cls == tsc_pkg::CLS_ERROR);
  assign period = (len_q != '0) && hit && (hit_idx == tsc_pkg::IDX_PERIOD);

  // next state and result words
  always_comb begin
    mask_d   = mask_q;
    lower_d  = lower_q;
    len_d    = len_q;
    paren_d  = paren_q;
    brace_d  = brace_q;
    ovf_d    = ovf_q;
    halted_d = halted_q;
    sum_word = '0;

    tok_word                   = '0;
    tok_word.result_kind       = tsc_pkg::KIND_TOKEN;
    tok_word.token_class       = cls;
    tok_word.brackets_balanced = 1'b0;
    tok_word.halt_cause        = is_err ? tsc_pkg::HALT_ERROR : tsc_pkg::HALT_PERIOD;
    tok_word.last              = 1'b0;

    push_o        = '0;
    push_o.count  = 2'd0;
    push_o.first  = tok_word;
    push_o.second = tok_word;

    if (en_i && !halted_q) begin
      if (eoi || space) begin
        // token ends: counters move with the matched delimiter
        if (len_q != '0 && hit) begin
          if (hit_idx == tsc_pkg::IDX_LPAREN) begin
            if (paren_q == CntMax) ovf_d = 1'b1;
            else paren_d = paren_q + CntOne;
          end
          if (hit_idx == tsc_pkg::IDX_RPAREN) begin
            if (paren_q == CntMin) ovf_d = 1'b1;
            else paren_d = paren_q - CntOne;
          end
          if (hit_idx == tsc_pkg::IDX_LBRACE) begin
            if (brace_q == CntMax) ovf_d = 1'b1;
            else brace_d = brace_q + CntOne;
          end
          if (hit_idx == tsc_pkg::IDX_RBRACE) begin
            if (brace_q == CntMin) ovf_d = 1'b1;
            else brace_d = brace_q - CntOne;
          end
        end
        mask_d  = '1;
        lower_d = 1'b1;
        len_d   = '0;
        if (len_q != '0) begin
          push_o.count = 2'd1;
          push_o.first = tok_word;
        end
        if (is_err) begin
          halted_d = 1'b1;
        end
        // summary closes the stream
        sum_word                   = '0;
        sum_word.result_kind       = tsc_pkg::KIND_SUMMARY;
        sum_word.token_class       = tsc_pkg::CLS_OP;
        sum_word.brackets_balanced = (paren_d == '0) && (brace_d == '0) && !ovf_d;
        sum_word.halt_cause        = period ? tsc_pkg::HALT_PERIOD : tsc_pkg::HALT_EOI;
        sum_word.last              = 1'b1;
        if (!is_err && (eoi || period)) begin
          halted_d = 1'b1;
          if (len_q != '0) begin
            push_o.count  = 2'd2;
            push_o.second = sum_word;
          end else begin
            push_o.count = 2'd1;
            push_o.first = sum_word;
          end
        end else begin
          push_o.first.last = 1'b1;
        end
      end else begin
        // token character
        mask_d = mask_q & keep;
        if ((word_i.ch < 8'h61) || (word_i.ch > 8'h7a)) lower_d = 1'b0;
        if (len_q != '1) len_d = len_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '1;
      lower_q  <= 1'b1;
      len_q    <= '0;
      paren_q  <= '0;
      brace_q  <= '0;
      ovf_q    <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      lower_q  <= lower_d;
      len_q    <= len_d;
      paren_q  <= paren_d;
      brace_q  <= brace_d;
      ovf_q    <= ovf_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ===== rtl/core/tsc_result_fifo.sv =====
// tsc_result_fifo: four-entry result queue, takes up to two words per cycle and
// hands out one; depends on tsc_pkg

module tsc_result_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tsc_pkg::tsc_push_t     push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tsc_pkg::tsc_out_word_t out_word_o
);

  tsc_pkg::tsc_out_word_t mem_q [4];
  logic [1:0] rd_q, rd_d, wr_q, wr_d, wr_nxt;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_word_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // room for the largest burst one word can cause
  assign room_o      = (cnt_q <= 3'd2);
  assign wr_nxt      = wr_q + 2'd1;

  // pointer and fill count update
  always_comb begin
    rd_d  = pop ? rd_q + 2'd1 : rd_q;
    wr_d  = wr_q + push_i.count;
    cnt_d = cnt_q + {1'b0, push_i.count} - {2'b00, pop};
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_nxt] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/token_stream_classifier_top.sv =====
// token_stream_classifier_top: input register, lexer and result queue
// depends on tsc_pkg, tsc_lexer and tsc_result_fifo

// Byte-stream lexer: one character word per cycle, whitespace (9 to 13, 32)
// ends a token, and each finished token yields a class word. A period token or
// an end-of-input word adds a bracket balance summary and stops the block; an
// error token stops it too, and only reset starts it again. An input word is
// registered, then classified combinationally and written into a four-entry
// result queue, so the sustained rate is one word per cycle; the input stalls
// only while the queue holds three or more words, which happens only when the
// output side stalls. A result word passes the input register and the queue
// storage before it is valid, and is taken at an edge with no output stall.

module token_stream_classifier_top #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  tsc_pkg::tsc_in_word_t  in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tsc_pkg::tsc_out_word_t out_word_o
);

  logic                  in_valid_q;
  tsc_pkg::tsc_in_word_t in_word_q;
  logic                  room;
  tsc_pkg::tsc_push_t    push;

  // held word waits while the queue is near full
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) in_word_q <= in_word_i;
  end

  // classification
  tsc_lexer #(
    .COUNT_BITS(COUNT_BITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_valid_q && room),
    .word_i (in_word_q),
    .push_o (push)
  );

  // result queue
  tsc_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
